>>> src/ccew_pkg.sv
// shared types, sizes and helper functions of the cyclic code encoder
// used by ccew_cell, ccew_finish and cyclic_code_encoder_with_weight
package ccew_pkg;

   localparam int MSG_BITS       = 16;
   localparam int MAX_GEN_DEGREE = 16;
   localparam int GEN_BITS       = MAX_GEN_DEGREE + 1;
   localparam int REM_BITS       = MAX_GEN_DEGREE;
   localparam int CW_BITS        = MSG_BITS + MAX_GEN_DEGREE;
   localparam int DEG_BITS       = $clog2(MAX_GEN_DEGREE + 1);
   localparam int WEIGHT_BITS    = $clog2(CW_BITS + 1);
   localparam int NUM_CELLS      = MSG_BITS;

   localparam logic [GEN_BITS-1:0] GEN_RESET = GEN_BITS'(11);

   typedef logic [MSG_BITS-1:0]    msg_type;
   typedef logic [GEN_BITS-1:0]    gen_type;
   typedef logic [REM_BITS-1:0]    rem_type;
   typedef logic [CW_BITS-1:0]     cw_type;
   typedef logic [DEG_BITS-1:0]    deg_type;
   typedef logic [WEIGHT_BITS-1:0] weight_type;

   typedef struct packed {
      logic       valid;
      msg_type    msg;
      rem_type    rem;
      weight_type ones;
   } cell_data_type;

   typedef struct packed {
      deg_type degree;
      rem_type gen_lo;
   } gen_cfg_type;

   // degree and generator tail aligned to the top of the remainder word
   function automatic gen_cfg_type align_gen(input gen_type poly);
      gen_type     g;
      gen_type     shifted;
      deg_type     d;
      gen_cfg_type res;
      g = (poly == '0) ? GEN_BITS'(1) : poly;
      d = '0;
      for (int i = 0; i < GEN_BITS; i++) begin
         if (g[i]) begin
            d = DEG_BITS'(i);
         end
      end
      shifted    = g << (DEG_BITS'(MAX_GEN_DEGREE) - d);
      res.degree = d;
      res.gen_lo = shifted[REM_BITS-1:0];
      return res;
   endfunction

   function automatic weight_type popcount_rem(input rem_type v);
      weight_type n;
      n = '0;
      for (int i = 0; i < REM_BITS; i++) begin
         n = n + WEIGHT_BITS'(v[i]);
      end
      return n;
   endfunction

endpackage

>>> src/ccew_cell.sv
// one division cell: folds one message bit into the remainder and counts it
// depends on ccew_pkg
module ccew_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   enable,
   input  ccew_pkg::rem_type      gen_lo,
   input  ccew_pkg::cell_data_type up,
   output ccew_pkg::cell_data_type down
);
   import ccew_pkg::*;

   logic       feedback;
   logic       valid_ff;
   msg_type    msg_in, msg_ff;
   rem_type    rem_in, rem_ff;
   weight_type ones_in, ones_ff;

   always_comb begin
      feedback = up.msg[MSG_BITS-1] ^ up.rem[REM_BITS-1];
      // rotate so the next cell sees the next bit and the word comes back whole
      msg_in   = (up.msg << 1) | (up.msg >> (MSG_BITS - 1));
      rem_in   = (up.rem << 1) ^ (feedback ? gen_lo : '0);
      ones_in  = up.ones + WEIGHT_BITS'(up.msg[MSG_BITS-1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= up.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         msg_ff  <= msg_in;
         rem_ff  <= rem_in;
         ones_ff <= ones_in;
      end
   end

   assign down = '{valid: valid_ff, msg: msg_ff, rem: rem_ff, ones: ones_ff};

endmodule

>>> src/ccew_finish.sv
// output stage: realigns the remainder, builds the codeword and its weight
// depends on ccew_pkg
module ccew_finish (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    enable,
   input  ccew_pkg::deg_type       degree,
   input  ccew_pkg::cell_data_type last,
   output logic                    rsp_valid,
   output ccew_pkg::rem_type       rsp_check_bits,
   output ccew_pkg::cw_type        rsp_codeword,
   output ccew_pkg::weight_type    rsp_code_weight
);
   import ccew_pkg::*;

   logic       valid_ff;
   rem_type    check_in, check_ff;
   cw_type     codeword_in, codeword_ff;
   weight_type weight_in, weight_ff;

   always_comb begin
      check_in    = last.rem >> (DEG_BITS'(MAX_GEN_DEGREE) - degree);
      codeword_in = (CW_BITS'(last.msg) << degree) | CW_BITS'(check_in);
      weight_in   = last.ones + popcount_rem(last.rem);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= last.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         check_ff    <= check_in;
         codeword_ff <= codeword_in;
         weight_ff   <= weight_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_check_bits  = check_ff;
   assign rsp_codeword    = codeword_ff;
   assign rsp_code_weight = weight_ff;

endmodule

>>> src/cyclic_code_encoder_with_weight.sv
// top level of the systematic cyclic code encoder with codeword weight
// depends on ccew_pkg, ccew_cell and ccew_finish
//
// usage
//  - csr channel: one beat writes the generator polynomial (bit i is x^i);
//    csr_ready is always high, write only while the encoder is empty
//  - req channel: one beat carries one message; rsp channel: one beat returns
//    check bits, codeword and codeword weight for that message, in order
//  - path: a req beat loads the first cell register itself, then the message
//    moves through the 16 cell registers and the output register to the rsp
//    channel; a stall holds it in place
//  - throughput: one message per cycle while the row is not held, set by the
//    row of 16 division cells that all advance together
//  - the whole row and the output register hold while rsp_valid is high and
//    rsp_ready is low; req_ready drops in that case
//  - reset empties the row and loads generator x^3 + x + 1; a zero
//    generator acts as the generator 1
module cyclic_code_encoder_with_weight (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  ccew_pkg::msg_type    req_message,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output ccew_pkg::rem_type    rsp_check_bits,
   output ccew_pkg::cw_type     rsp_codeword,
   output ccew_pkg::weight_type rsp_code_weight,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  ccew_pkg::gen_type    csr_generator_poly
);
   import ccew_pkg::*;

   logic          advance;
   gen_cfg_type   gen_cfg_ff;
   cell_data_type chain [NUM_CELLS+1];

   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_cfg_ff <= align_gen(GEN_RESET);
      end else if (csr_valid && csr_ready) begin
         gen_cfg_ff <= align_gen(csr_generator_poly);
      end
   end

   assign chain[0] = '{valid: req_valid, msg: req_message, rem: '0, ones: '0};

   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      ccew_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .enable (advance),
         .gen_lo (gen_cfg_ff.gen_lo),
         .up     (chain[i]),
         .down   (chain[i+1])
      );
   end

   ccew_finish u_finish (
      .clock           (clock),
      .reset           (reset),
      .enable          (advance),
      .degree          (gen_cfg_ff.degree),
      .last            (chain[NUM_CELLS]),
      .rsp_valid       (rsp_valid),
      .rsp_check_bits  (rsp_check_bits),
      .rsp_codeword    (rsp_codeword),
      .rsp_code_weight (rsp_code_weight)
   );

   a_weight_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_code_weight == WEIGHT_BITS'($countones(rsp_codeword)))
      else $error("codeword weight mismatch");

   a_check_in_codeword: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_codeword[REM_BITS-1:0] & rsp_check_bits) == rsp_check_bits)
      else $error("check bits missing from codeword");

   a_check_below_degree: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (CW_BITS'(rsp_check_bits) >> gen_cfg_ff.degree) == '0)
      else $error("check bits reach generator degree");

   a_last_cell_holds: assert property (@(posedge clock) disable iff (reset)
      chain[NUM_CELLS].valid && !advance |=> $stable(chain[NUM_CELLS]))
      else $error("cell row moved during stall");

endmodule

>>> tb/cyclic_code_encoder_with_weight_tb.sv
// self-checking testbench for cyclic_code_encoder_with_weight: random and directed messages
// under several generator polynomials, predicted by long division and checked beat by beat
// depends on ccew_pkg and the encoder RTL
module cyclic_code_encoder_with_weight_tb;
   import ccew_pkg::*;

   localparam int STALL_LIMIT   = 1000;
   localparam int DRAIN_CYCLES  = 20;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_BEATS   = 110;
   localparam int LONG_HOLD     = 80;

   typedef struct packed {
      rem_type    check;
      cw_type     codeword;
      weight_type weight;
   } code_result_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   msg_type    req_message = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   rem_type    rsp_check_bits;
   cw_type     rsp_codeword;
   weight_type rsp_code_weight;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   gen_type    csr_generator_poly = '0;

   msg_type         pending_messages[$];
   code_result_type expected_codes[$];
   gen_type         active_generator = GEN_RESET;
   logic            req_took = 1'b0;
   int              stall_cycles = 0;
   int              mismatch_count = 0;
   int              send_idle_pct = 36;
   int              recv_idle_pct = 36;
   logic            long_hold = 1'b0;
   logic            hold_taken = 1'b0;
   int              hold_left = 0;

   cyclic_code_encoder_with_weight u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_message        (req_message),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_check_bits     (rsp_check_bits),
      .rsp_codeword       (rsp_codeword),
      .rsp_code_weight    (rsp_code_weight),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_generator_poly (csr_generator_poly)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic code_result_type encode_message(input gen_type poly,
                                                      input msg_type msg);
      logic [63:0]     g;
      logic [63:0]     shifted;
      logic [63:0]     rem;
      int              deg;
      code_result_type res;
      g = (poly == '0) ? 64'd1 : 64'(poly);
      deg = 0;
      for (int i = 0; i < GEN_BITS; i++) begin
         if (g[i]) begin
            deg = i;
         end
      end
      shifted = 64'(msg) << deg;
      rem = shifted;
      for (int i = 63; i >= deg; i--) begin
         if (rem[i]) begin
            rem = rem ^ (g << (i - deg));
         end
      end
      res.check    = rem[REM_BITS-1:0];
      res.codeword = shifted[CW_BITS-1:0] ^ rem[CW_BITS-1:0];
      res.weight   = WEIGHT_BITS'($countones(res.codeword));
      return res;
   endfunction

   function automatic msg_type pick_message();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         2: return msg_type'(1) << $urandom_range(MSG_BITS - 1);
         3: return ~(msg_type'(1) << $urandom_range(MSG_BITS - 1));
         default: return msg_type'($urandom);
      endcase
   endfunction

   function automatic gen_type pick_generator();
      int          deg;
      int unsigned bits;
      deg  = $urandom_range(MAX_GEN_DEGREE - 1);
      bits = $urandom;
      case ($urandom_range(5))
         0: return gen_type'(bits) | (gen_type'(1) << MAX_GEN_DEGREE);
         1: return gen_type'((bits & ((32'd1 << deg) - 1)) | (32'd1 << deg));
         2: return gen_type'($urandom_range(1));
         default: return gen_type'(bits);
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      $display("mismatch %s: got %0h expected %0h", what, got, want);
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_messages.size() != 0 || expected_codes.size() != 0 || req_valid);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_generator(input gen_type poly);
      wait_drained();
      csr_valid <= 1'b1;
      csr_generator_poly <= poly;
      do @(posedge clock);
      while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (pending_messages.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid   <= 1'b1;
            req_message <= pending_messages.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response receiver, with one long hold-off on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (long_hold && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left  <= LONG_HOLD;
         rsp_ready  <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : monitor
      code_result_type want;
      if (reset) begin
         req_took         <= 1'b0;
         stall_cycles     <= 0;
         active_generator <= GEN_RESET;
      end else begin
         req_took <= req_valid && req_ready;
         if (csr_valid && csr_ready) begin
            active_generator <= csr_generator_poly;
         end
         if (req_valid && req_ready) begin
            expected_codes.push_back(encode_message(active_generator, req_message));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_codes.size() == 0) begin
               report_mismatch("beat with nothing expected", rsp_codeword, '0);
            end else begin
               want = expected_codes.pop_front();
               if (rsp_check_bits !== want.check) begin
                  report_mismatch("check_bits", 32'(rsp_check_bits), 32'(want.check));
               end
               if (rsp_codeword !== want.codeword) begin
                  report_mismatch("codeword", rsp_codeword, want.codeword);
               end
               if (rsp_code_weight !== want.weight) begin
                  report_mismatch("code_weight", 32'(rsp_code_weight), 32'(want.weight));
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready)) begin
            stall_cycles <= 0;
         end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   initial begin : stimulus
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset generator x^3 + x + 1
      pending_messages.push_back(16'h0000);
      pending_messages.push_back(16'hFFFF);
      pending_messages.push_back(16'h0001);
      pending_messages.push_back(16'h8000);
      pending_messages.push_back(16'hAAAA);
      pending_messages.push_back(16'h5555);

      // degree zero generator
      write_generator(gen_type'(1));
      pending_messages.push_back(16'h0000);
      pending_messages.push_back(16'hFFFF);
      pending_messages.push_back(16'h1234);

      // zero generator acts as one
      write_generator('0);
      pending_messages.push_back(16'hFFFF);
      pending_messages.push_back(16'h8001);

      // all ones, full degree
      write_generator('1);
      pending_messages.push_back(16'hFFFF);
      pending_messages.push_back(16'h0001);
      pending_messages.push_back(16'h8000);
      pending_messages.push_back(16'h0000);

      // bare x^16
      write_generator(gen_type'(1) << MAX_GEN_DEGREE);
      pending_messages.push_back(16'hFFFF);
      pending_messages.push_back(16'h0001);
      pending_messages.push_back(16'hA5A5);

      // bare x
      write_generator(gen_type'(2));
      pending_messages.push_back(16'hFFFF);
      pending_messages.push_back(16'h8000);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         write_generator(pick_generator());
         send_idle_pct = (p == 3 || p == 6) ? 0 : 36;
         recv_idle_pct = (p == 3) ? 0 : 36;
         if (p == 6) begin
            long_hold = 1'b1;
         end
         repeat (PHASE_BEATS) pending_messages.push_back(pick_message());
      end

      wait_drained();
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
